### rtl/atan2_pkg.sv
// ----------------------------------------------------------------------------
// atan2_pkg
// Shared constants, pipeline control type and the table builder for the
// fixed-point atan2 block.
// ----------------------------------------------------------------------------
package atan2_pkg;

   localparam int FRAC_BITS_DEF   = 16;
   localparam int TABLE_STEPS_DEF = 200;
   localparam int COORD_W         = 32;
   localparam int ANGLE_W         = 25;

   typedef struct packed {
      logic valid;
      logic zero;
      logic mirror;
      logic xneg;
      logic yneg;
      logic xzero;
   } ctl_type;

   // atan(i/n) in degrees with f fraction bits, rounded half up
   function automatic longint atan_entry(input int i, input int n, input int f);
      real r;
      r = $atan2(real'(i), real'(n)) * 57.29577951308232 * (2.0 ** f);
      return longint'($floor(r + 0.5));
   endfunction

endpackage

### rtl/atan2_lut_degrees.sv
// ----------------------------------------------------------------------------
// atan2_lut_degrees
// Four-quadrant arctangent in degrees: restoring divide of the smaller
// magnitude by the larger, table lookup with linear interpolation, quadrant fix.
// ----------------------------------------------------------------------------
//  channel   ports                            handshake
//  request   req_x_coord, req_y_coord         start high and busy low
//  response  rsp_angle_deg                    rsp_valid, one cycle, no stall
//
//  One pair enters per cycle; busy stays low.
//  The pipeline has one magnitude stage, FRAC_BITS + 1
//  divider stages (one quotient bit each), then scale, lookup, interpolate
//  and quadrant stages.
//  Reset clears all valid bits; data in flight is dropped.
module atan2_lut_degrees
   import atan2_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int TABLE_STEPS = TABLE_STEPS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_x_coord,
   input  logic signed [COORD_W-1:0] req_y_coord,
   output logic                      rsp_valid,
   output logic [ANGLE_W-1:0]        rsp_angle_deg
);

   localparam int MAG_W  = COORD_W;
   localparam int REM_W  = MAG_W + 1;
   localparam int QUO_W  = FRAC_BITS + 1;
   localparam int DIV_N  = FRAC_BITS + 1;
   localparam int IDX_W  = $clog2(TABLE_STEPS + 1);
   localparam int POS_W  = QUO_W + IDX_W;
   localparam int ROM_W  = FRAC_BITS + 6;
   localparam int DIFF_W = FRAC_BITS + 1;
   localparam int ANG_W  = FRAC_BITS + 9;
   localparam int LAT    = FRAC_BITS + 6;

   localparam logic [ANG_W-1:0] FX90  = ANG_W'(90)  << FRAC_BITS;
   localparam logic [ANG_W-1:0] FX180 = ANG_W'(180) << FRAC_BITS;
   localparam logic [ANG_W-1:0] FX360 = ANG_W'(360) << FRAC_BITS;

   typedef logic [ROM_W-1:0] rom_arr_type [TABLE_STEPS+1];

   function automatic rom_arr_type build_rom();
      rom_arr_type t;
      for (int i = 0; i <= TABLE_STEPS; i++) begin
         t[i] = ROM_W'(atan_entry(i, TABLE_STEPS, FRAC_BITS));
      end
      return t;
   endfunction

   localparam rom_arr_type ROM = build_rom();

   assign busy = 1'b0;

   // ---------------- magnitude stage ----------------
   logic [MAG_W-1:0] xm, ym;
   logic [MAG_W-1:0] big_ff, small_ff;
   ctl_type          a_ctl_in, a_ctl_ff;

   always_comb begin
      xm = req_x_coord[MAG_W-1] ? (~req_x_coord + 1'b1) : req_x_coord;
      ym = req_y_coord[MAG_W-1] ? (~req_y_coord + 1'b1) : req_y_coord;
      a_ctl_in.valid  = start & ~busy;
      a_ctl_in.zero   = (req_x_coord == '0) && (req_y_coord == '0);
      a_ctl_in.mirror = xm < ym;
      a_ctl_in.xneg   = req_x_coord[MAG_W-1];
      a_ctl_in.yneg   = req_y_coord[MAG_W-1];
      a_ctl_in.xzero  = (req_x_coord == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
      end else begin
         a_ctl_ff <= a_ctl_in;
      end
      big_ff   <= a_ctl_in.mirror ? ym : xm;
      small_ff <= a_ctl_in.mirror ? xm : ym;
   end

   // ---------------- divider: one quotient bit per stage ----------------
   logic [MAG_W-1:0] div_rem_ff [DIV_N];
   logic [MAG_W-1:0] div_big_ff [DIV_N];
   logic [QUO_W-1:0] div_quo_ff [DIV_N];
   ctl_type          div_ctl_ff [DIV_N];

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      logic [MAG_W-1:0] rem_prev, big_prev;
      logic [QUO_W-1:0] quo_prev;
      ctl_type          ctl_prev;
      logic [REM_W-1:0] shifted;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_prev = small_ff;
         assign big_prev = big_ff;
         assign quo_prev = '0;
         assign ctl_prev = a_ctl_ff;
         assign shifted  = {1'b0, rem_prev};
      end else begin : g_next
         assign rem_prev = div_rem_ff[k-1];
         assign big_prev = div_big_ff[k-1];
         assign quo_prev = div_quo_ff[k-1];
         assign ctl_prev = div_ctl_ff[k-1];
         assign shifted  = {rem_prev, 1'b0};
      end

      assign ge = shifted >= {1'b0, big_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            div_ctl_ff[k] <= '0;
         end else begin
            div_ctl_ff[k] <= ctl_prev;
         end
         div_rem_ff[k] <= ge ? MAG_W'(shifted - {1'b0, big_prev}) : MAG_W'(shifted);
         div_big_ff[k] <= big_prev;
         div_quo_ff[k] <= {quo_prev[QUO_W-2:0], ge};
      end
   end

   // ---------------- scale by table steps ----------------
   logic [POS_W-1:0] pos;
   logic [IDX_W-1:0] idx_ff;
   logic [FRAC_BITS-1:0] frac_ff;
   ctl_type          p_ctl_ff;

   assign pos = POS_W'(div_quo_ff[DIV_N-1]) * POS_W'(TABLE_STEPS);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ctl_ff <= '0;
      end else begin
         p_ctl_ff <= div_ctl_ff[DIV_N-1];
      end
      // saturate at full scale
      if (pos[POS_W-1:FRAC_BITS] >= (POS_W-FRAC_BITS)'(TABLE_STEPS)) begin
         idx_ff  <= IDX_W'(TABLE_STEPS);
         frac_ff <= '0;
      end else begin
         idx_ff  <= IDX_W'(pos[POS_W-1:FRAC_BITS]);
         frac_ff <= pos[FRAC_BITS-1:0];
      end
   end

   // ---------------- table lookup ----------------
   logic [ROM_W-1:0]     lo_val, hi_val;
   logic [ROM_W-1:0]     lo_ff;
   logic [DIFF_W-1:0]    diff_ff;
   logic [FRAC_BITS-1:0] l_frac_ff;
   ctl_type              l_ctl_ff;

   always_comb begin
      lo_val = ROM[idx_ff];
      if (idx_ff < IDX_W'(TABLE_STEPS)) begin
         hi_val = ROM[idx_ff + 1'b1];
      end else begin
         hi_val = lo_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_ctl_ff <= '0;
      end else begin
         l_ctl_ff <= p_ctl_ff;
      end
      lo_ff     <= lo_val;
      diff_ff   <= (hi_val >= lo_val) ? DIFF_W'(hi_val - lo_val) : '0;
      l_frac_ff <= frac_ff;
   end

   // ---------------- interpolate ----------------
   logic [DIFF_W+FRAC_BITS-1:0] prod;
   logic [ANG_W-1:0]            m_ang_ff;
   ctl_type                     m_ctl_ff;

   assign prod = (DIFF_W+FRAC_BITS)'(diff_ff) * (DIFF_W+FRAC_BITS)'(l_frac_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ctl_ff <= '0;
      end else begin
         m_ctl_ff <= l_ctl_ff;
      end
      m_ang_ff <= ANG_W'(lo_ff) + ANG_W'(prod >> FRAC_BITS);
   end

   // ---------------- mirror and quadrant ----------------
   logic [ANG_W-1:0] oct_ang, quad_ang;
   logic [ANG_W-1:0] out_ff;
   logic             out_valid_ff;

   always_comb begin
      oct_ang = m_ctl_ff.mirror ? (FX90 - m_ang_ff) : m_ang_ff;
      priority if (m_ctl_ff.zero) begin
         quad_ang = '0;
      end else if (!m_ctl_ff.yneg && m_ctl_ff.xneg) begin
         quad_ang = FX180 - oct_ang;
      end else if (m_ctl_ff.yneg && (m_ctl_ff.xneg || m_ctl_ff.xzero)) begin
         quad_ang = oct_ang + FX180;
      end else if (m_ctl_ff.yneg) begin
         quad_ang = FX360 - oct_ang;
      end else begin
         quad_ang = oct_ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= m_ctl_ff.valid;
      end
      out_ff <= quad_ang;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_angle_deg = ANGLE_W'(out_ff);

   // ---------------- assertions ----------------
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted beat did not appear after pipeline latency");

   a_latency_bwd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("response beat without matching request");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (out_ff <= FX360))
      else $error("angle above full circle");

endmodule

### tb/sv/atan2_angle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atan2_angle_checker
// Watches the coordinate and angle channels of the atan2 block, predicts the
// angle in degrees for every accepted pair and compares it in order.
// ----------------------------------------------------------------------------
module atan2_angle_checker
   import atan2_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int TABLE_STEPS = TABLE_STEPS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic signed [COORD_W-1:0] req_x_coord,
   input  logic signed [COORD_W-1:0] req_y_coord,
   input  logic                      rsp_valid,
   input  logic [ANGLE_W-1:0]        rsp_angle_deg,
   output int                        fail_count,
   output int                        angles_pending
);

   localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

   longint unsigned      atan_deg_rom [0:TABLE_STEPS];
   logic [ANGLE_W-1:0]   angle_queue [$];

   initial begin
      real deg;
      fail_count = 0;
      for (int i = 0; i <= TABLE_STEPS; i++) begin
         deg = $atan(real'(i) / real'(TABLE_STEPS)) * 57.29577951308232
               * real'(ONE);
         atan_deg_rom[i] = longint'($floor(deg + 0.5));
      end
   end

   assign angles_pending = angle_queue.size();

   function automatic logic [ANGLE_W-1:0] angle_of(logic [31:0] x, logic [31:0] y);
      longint unsigned xm, ym, big, little, ratio, pos, idx, frac, lo, hi, ang;
      logic mirror;
      if (x == 0 && y == 0) return '0;
      xm = x[31] ? longint'(-{32'd0, x}) & 64'hFFFF_FFFF : {32'd0, x};
      ym = y[31] ? longint'(-{32'd0, y}) & 64'hFFFF_FFFF : {32'd0, y};
      mirror = xm < ym;
      big    = mirror ? ym : xm;
      little = mirror ? xm : ym;
      ratio = (little << FRAC_BITS) / big;
      pos   = ratio * TABLE_STEPS;
      idx   = pos >> FRAC_BITS;
      frac  = pos & (ONE - 1);
      if (idx >= TABLE_STEPS) begin
         idx  = TABLE_STEPS;
         frac = 0;
      end
      lo  = atan_deg_rom[idx];
      hi  = (idx < TABLE_STEPS) ? atan_deg_rom[idx + 1] : lo;
      ang = lo + ((((hi >= lo) ? (hi - lo) : 0) * frac) >> FRAC_BITS);
      if (mirror) ang = 90 * ONE - ang;
      // place into quadrant; x == 0 with y < 0 goes to the 180 + a branch
      if (!y[31] && x[31])             ang = 180 * ONE - ang;
      else if (y[31] && (x[31] || x == 0)) ang = ang + 180 * ONE;
      else if (y[31])                  ang = 360 * ONE - ang;
      return ang[ANGLE_W-1:0];
   endfunction

   task automatic report(string what, logic [ANGLE_W-1:0] got, logic [ANGLE_W-1:0] want);
      $display("%0t angle mismatch (%s): got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [ANGLE_W-1:0] want;
      if (!reset) begin
         if (start && !busy)
            angle_queue.push_back(angle_of(req_x_coord, req_y_coord));
         if (rsp_valid) begin
            if (angle_queue.size() == 0) begin
               report("no beat expected", rsp_angle_deg, '0);
            end else begin
               want = angle_queue.pop_front();
               if (rsp_angle_deg !== want) report("angle_deg", rsp_angle_deg, want);
            end
         end
      end
   end

   final begin
      if (angle_queue.size() != 0)
         $display("%0d angle beats never arrived", angle_queue.size());
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives coordinate pairs into the atan2 block with random or no gaps:
// directed corner pairs first, then random pairs of mixed magnitude ratios.
// ----------------------------------------------------------------------------
module tb;
   import atan2_pkg::*;

   localparam int LATENCY   = FRAC_BITS_DEF + 6;
   localparam int STALL_MAX = 2000;

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      start = 0;
   logic                      busy;
   logic signed [COORD_W-1:0] req_x_coord = '0;
   logic signed [COORD_W-1:0] req_y_coord = '0;
   logic                      rsp_valid;
   logic [ANGLE_W-1:0]        rsp_angle_deg;
   int                        fail_count;
   int                        angles_pending;
   int                        quiet_cycles = 0;
   bit                        no_gaps = 0;

   always #5 clock = ~clock;

   atan2_lut_degrees dut (.*);
   atan2_angle_checker checker_i (.*);

   // end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_MAX) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   task automatic send_pair(logic [31:0] x, logic [31:0] y);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
      start       <= 1;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      logic [31:0] v;
      v = $urandom();
      case ($urandom_range(0, 3))
         0: v = v >>> $urandom_range(0, 31);
         1: v = $signed(v) >>> $urandom_range(0, 31);
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      logic [31:0] x, y, m;
      repeat (10) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // corners: zero, extremes, most negative, equal magnitudes, axes
      send_pair(0, 0);
      send_pair(32'h7FFF_FFFF, 0);
      send_pair(0, 32'h7FFF_FFFF);
      send_pair(32'h8000_0001, 0);
      send_pair(0, 32'h8000_0001);
      send_pair(32'h8000_0000, 0);
      send_pair(0, 32'h8000_0000);
      send_pair(32'h8000_0000, 32'h8000_0000);
      send_pair(32'h8000_0000, 32'h7FFF_FFFF);
      send_pair(32'h7FFF_FFFF, 32'h8000_0000);
      send_pair(32'h0001_0000, 32'h0001_0000);
      send_pair(-32'sd65536, 32'h0001_0000);
      send_pair(-32'sd65536, -32'sd65536);
      send_pair(32'h0001_0000, -32'sd65536);
      send_pair(1, -1);
      send_pair(0, -1);
      send_pair(-1, 0);
      send_pair(32'h7FFF_FFFF, -1);
      send_pair(-1, 32'h7FFF_FFFF);
      send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFE);
      send_pair(100000, 99999);
      send_pair(3, 2);
      send_pair(-5, -3);

      // hold until the pipeline drains
      start <= 0;
      while (angles_pending != 0) @(negedge clock);

      for (int n = 0; n < 450; n++) begin
         if (n % 100 == 0) no_gaps = ($urandom_range(0, 2) == 0);
         x = rand_coord();
         case ($urandom_range(0, 4))
            0: y = rand_coord();
            1: y = $urandom_range(0, 1) ? x : -x;
            2: begin
               // ratio near a table step boundary
               m = x[31] ? -x : x;
               y = (m / 200) * $urandom_range(0, 200) + $urandom_range(0, 3);
               if ($urandom_range(0, 1)) y = -y;
               if ($urandom_range(0, 1)) {x, y} = {y, x};
            end
            default: y = $urandom();
         endcase
         send_pair(x, y);
      end
      start <= 0;

      while (angles_pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (fail_count == 0 && angles_pending == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
